>>> hw/rtl/ale_pkg.sv
`timescale 1ns / 1ps

package ale_pkg;

	localparam int DATA_W = 32;

	localparam logic [2:0] REQ_INS_FRONT = 3'd0;
	localparam logic [2:0] REQ_INS_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT = 3'd2;
	localparam logic [2:0] REQ_POP_BACK  = 3'd3;
	localparam logic [2:0] REQ_REMOVE    = 3'd4;
	localparam logic [2:0] REQ_COUNT     = 3'd5;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_NOMATCH = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     wr_en;
	} cell_ctl_t;

endpackage

>>> hw/rtl/ale_cell.sv
`timescale 1ns / 1ps

module ale_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  logic                        clk,
	input  ale_pkg::cell_ctl_t          ctl,
	input  logic [IW-1:0]               wr_idx,
	input  logic [ale_pkg::DATA_W-1:0]  wr_data,
	input  logic [IW-1:0]               rd_idx,
	input  logic [ale_pkg::DATA_W-1:0]  from_lo,
	input  logic [ale_pkg::DATA_W-1:0]  from_hi,
	output logic [ale_pkg::DATA_W-1:0]  data,
	output logic [ale_pkg::DATA_W-1:0]  rd_data
);

	logic [ale_pkg::DATA_W-1:0] data_q;
	logic                       wr_hit;
	logic                       rd_hit;

	assign wr_hit  = ctl.wr_en && (wr_idx == IW'(IDX));
	assign rd_hit  = (rd_idx == IW'(IDX));
	assign data    = data_q;
	assign rd_data = rd_hit ? data_q : '0;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			data_q <= wr_data;
		end else begin
			case (ctl.op)
				ale_pkg::CELL_SHIFT_UP:   data_q <= from_lo;
				ale_pkg::CELL_SHIFT_DOWN: data_q <= from_hi;
				default:                  data_q <= data_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/array_list_engine_top.sv
`timescale 1ns / 1ps
// Insert and pop requests: result on done the cycle after the transfer; one per idle cycle.
// Remove-all and count: the list rotates once through the head cell of the cell chain,
// one entry per cycle, with busy high throughout, and done follows.
// Remove or count on an empty list completes without rotating. The receiver cannot stall.
// Reset empties the list (length zero, no result pending); entry contents are undefined.
module array_list_engine_top #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic [4:0]         match_count,
	output logic signed [31:0] removed_value,
	output logic [4:0]         length
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_SWEEP = 2'b10
	} state_t;

	state_t                     state_q;
	logic [LW-1:0]              len_q;
	logic [LW-1:0]              cnt_q;
	logic [LW-1:0]              match_q;
	logic                       done_q;
	logic [ale_pkg::DATA_W-1:0] v_q;
	logic                       rm_q;
	logic [1:0]                 status_q;
	logic [4:0]                 match_cnt_q;
	logic [ale_pkg::DATA_W-1:0] removed_q;
	logic [4:0]                 length_q;

	ale_pkg::cell_ctl_t         ctl;
	logic [IW-1:0]              wr_idx;
	logic [IW-1:0]              rd_idx;
	logic [ale_pkg::DATA_W-1:0] wr_data;
	logic [ale_pkg::DATA_W-1:0] cell_data [DEPTH];
	logic [ale_pkg::DATA_W-1:0] cell_rd [DEPTH];
	logic [ale_pkg::DATA_W-1:0] tail;
	logic [ale_pkg::DATA_W-1:0] head;
	logic                       head_eq;
	logic                       full;
	logic                       empty;
	logic                       accept;
	logic [LW-1:0]              len_inc;
	logic [LW-1:0]              len_dec;
	logic [LW-1:0]              len_sw;
	logic [LW-1:0]              match_nxt;

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && (state_q == S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign match_count   = match_cnt_q;
	assign removed_value = removed_q;
	assign length        = length_q;

	assign head      = cell_data[0];
	assign head_eq   = (head == v_q);
	assign full      = (len_q == LW'(DEPTH));
	assign empty     = (len_q == '0);
	assign len_inc   = len_q + LW'(1);
	assign len_dec   = len_q - LW'(1);
	assign len_sw    = (head_eq && rm_q) ? len_dec : len_q;
	assign match_nxt = match_q + LW'(head_eq);
	assign rd_idx    = IW'(len_dec);

	always_comb begin
		ctl.op    = ale_pkg::CELL_HOLD;
		ctl.wr_en = 1'b0;
		wr_idx    = IW'(len_q);
		wr_data   = value;
		if (state_q == S_SWEEP) begin
			ctl.op    = ale_pkg::CELL_SHIFT_DOWN;
			ctl.wr_en = !(head_eq && rm_q);
			wr_idx    = IW'(len_dec);
			wr_data   = head;
		end else if (accept) begin
			case (req_type)
				ale_pkg::REQ_INS_FRONT: if (!full) ctl.op = ale_pkg::CELL_SHIFT_UP;
				ale_pkg::REQ_INS_BACK:  ctl.wr_en = !full;
				ale_pkg::REQ_POP_FRONT: if (!empty) ctl.op = ale_pkg::CELL_SHIFT_DOWN;
				default:                ctl.op = ale_pkg::CELL_HOLD;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ale_pkg::DATA_W-1:0] lo;
		logic [ale_pkg::DATA_W-1:0] hi;
		if (i == 0) begin : g_lo_end
			assign lo = value;
		end else begin : g_lo
			assign lo = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi_end
			assign hi = '0;
		end else begin : g_hi
			assign hi = cell_data[i+1];
		end
		ale_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_idx  (wr_idx),
			.wr_data (wr_data),
			.rd_idx  (rd_idx),
			.from_lo (lo),
			.from_hi (hi),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	always_comb begin
		tail = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail = tail | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req_type)
							ale_pkg::REQ_INS_FRONT, ale_pkg::REQ_INS_BACK: begin
								done_q <= 1'b1;
								if (!full) len_q <= len_inc;
							end
							ale_pkg::REQ_POP_FRONT, ale_pkg::REQ_POP_BACK: begin
								done_q <= 1'b1;
								if (!empty) len_q <= len_dec;
							end
							ale_pkg::REQ_REMOVE, ale_pkg::REQ_COUNT: begin
								if (empty) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_SWEEP;
									cnt_q   <= len_q;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q - LW'(1);
					len_q <= len_sw;
					if (cnt_q == LW'(1)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SWEEP) begin
			match_q <= match_nxt;
			if (cnt_q == LW'(1)) begin
				status_q    <= (match_nxt == '0) ? ale_pkg::STAT_NOMATCH : ale_pkg::STAT_OK;
				match_cnt_q <= 5'(match_nxt);
				removed_q   <= '0;
				length_q    <= 5'(len_sw);
			end
		end else if (start) begin
			v_q         <= value;
			rm_q        <= (req_type == ale_pkg::REQ_REMOVE);
			match_q     <= '0;
			status_q    <= ale_pkg::STAT_OK;
			match_cnt_q <= '0;
			removed_q   <= '0;
			length_q    <= 5'(len_q);
			case (req_type)
				ale_pkg::REQ_INS_FRONT, ale_pkg::REQ_INS_BACK: begin
					if (full) status_q <= ale_pkg::STAT_FULL;
					else      length_q <= 5'(len_inc);
				end
				ale_pkg::REQ_POP_FRONT: begin
					if (empty) begin
						status_q <= ale_pkg::STAT_EMPTY;
					end else begin
						removed_q <= head;
						length_q  <= 5'(len_dec);
					end
				end
				ale_pkg::REQ_POP_BACK: begin
					if (empty) begin
						status_q <= ale_pkg::STAT_EMPTY;
					end else begin
						removed_q <= tail;
						length_q  <= 5'(len_dec);
					end
				end
				ale_pkg::REQ_REMOVE, ale_pkg::REQ_COUNT: begin
					if (empty) status_q <= ale_pkg::STAT_NOMATCH;
				end
				default: status_q <= ale_pkg::STAT_OK;
			endcase
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef struct {
		logic [1:0]         status;
		logic [4:0]         hit_count;
		logic signed [31:0] removed;
		logic [4:0]         len;
	} outcome_t;

	class list_tracker;
		logic signed [31:0] entries[$];
		outcome_t due_results[$];
		int capacity;
		int mismatches;
		int requests;
		int results;
		int full_refusals;
		int empty_refusals;
		int misses;

		function new(int depth);
			capacity = depth;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void apply_request(logic [2:0] req, logic signed [31:0] val);
			outcome_t o;
			logic signed [31:0] survivors[$];
			int hits;
			o = '{ale_pkg::STAT_OK, 5'd0, 32'sd0, 5'd0};
			hits = 0;
			requests++;
			case (req)
				ale_pkg::REQ_INS_FRONT, ale_pkg::REQ_INS_BACK: begin
					if (entries.size() >= capacity) begin
						o.status = ale_pkg::STAT_FULL;
						full_refusals++;
					end else if (req == ale_pkg::REQ_INS_FRONT) begin
						entries.push_front(val);
					end else begin
						entries.push_back(val);
					end
				end
				ale_pkg::REQ_POP_FRONT, ale_pkg::REQ_POP_BACK: begin
					if (entries.size() == 0) begin
						o.status = ale_pkg::STAT_EMPTY;
						empty_refusals++;
					end else if (req == ale_pkg::REQ_POP_FRONT) begin
						o.removed = entries.pop_front();
					end else begin
						o.removed = entries.pop_back();
					end
				end
				ale_pkg::REQ_REMOVE, ale_pkg::REQ_COUNT: begin
					foreach (entries[k]) begin
						if (entries[k] == val)
							hits++;
						else
							survivors.push_back(entries[k]);
					end
					if (req == ale_pkg::REQ_REMOVE)
						entries = survivors;
					o.hit_count = hits[4:0];
					if (hits == 0) begin
						o.status = ale_pkg::STAT_NOMATCH;
						misses++;
					end
				end
				default: ;
			endcase
			o.len = 5'(entries.size());
			due_results.push_back(o);
		endfunction

		function void check_result(logic [1:0] st, logic [4:0] mc, logic signed [31:0] rv,
				logic [4:0] len);
			outcome_t o;
			results++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result status=%0d count=%0d removed=%0d len=%0d",
						st, mc, rv, len);
				return;
			end
			o = due_results.pop_front();
			if (st !== o.status || mc !== o.hit_count || rv !== o.removed || len !== o.len) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result %0d exp status=%0d count=%0d removed=%0d len=%0d",
						results, o.status, o.hit_count, o.removed, o.len);
					$display("       got status=%0d count=%0d removed=%0d len=%0d",
						st, mc, rv, len);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         req_type;
	logic signed [31:0] value;
	logic               done;
	logic [1:0]         status;
	logic [4:0]         match_count;
	logic signed [31:0] removed_value;
	logic [4:0]         length;

	list_tracker tracker = new(LIST_DEPTH);
	int cycles;

	array_list_engine_top #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.status(status),
		.match_count(match_count),
		.removed_value(removed_value),
		.length(length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// results first: a result never belongs to the transfer at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(status, match_count, removed_value, length);
			if (start && !busy)
				tracker.apply_request(req_type, value);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic issue_request(logic [2:0] req, logic signed [31:0] val);
		start <= 1'b1;
		req_type <= req;
		value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic maybe_gap(bit calm);
		if (!calm && $urandom_range(99) < 37) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (LIST_DEPTH + 4)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5: return $urandom_range(7);
			6: return 32'sh5a5a_5a5a;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_request(bit filling);
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return 3'($urandom_range(7));
		if (filling) begin
			if (r < 34) return ale_pkg::REQ_INS_FRONT;
			if (r < 64) return ale_pkg::REQ_INS_BACK;
			if (r < 72) return ale_pkg::REQ_POP_FRONT;
			if (r < 80) return ale_pkg::REQ_POP_BACK;
			if (r < 88) return ale_pkg::REQ_REMOVE;
			return ale_pkg::REQ_COUNT;
		end
		if (r < 14) return ale_pkg::REQ_INS_FRONT;
		if (r < 24) return ale_pkg::REQ_INS_BACK;
		if (r < 48) return ale_pkg::REQ_POP_FRONT;
		if (r < 72) return ale_pkg::REQ_POP_BACK;
		if (r < 86) return ale_pkg::REQ_REMOVE;
		return ale_pkg::REQ_COUNT;
	endfunction

	initial begin
		logic signed [31:0] fill_values[16];
		bit filling;
		fill_values = '{32'sd5, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd5, -32'sd1, 32'sd0, 32'sd5,
			32'sh0f0f_f0f0, 32'sd5, 32'sh7fff_ffff, 32'sd1, 32'sd5, -32'sd2, 32'sh8000_0000,
			32'sd5, 32'sh1234_5678};
		arst_n = 1'b0;
		start = 1'b0;
		req_type = ale_pkg::REQ_INS_FRONT;
		value = 32'sd0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: refused pops, searches without a match, unused codes
		issue_request(ale_pkg::REQ_POP_FRONT, 32'sd0);
		issue_request(ale_pkg::REQ_POP_BACK, 32'sd0);
		issue_request(ale_pkg::REQ_REMOVE, 32'sd5);
		issue_request(ale_pkg::REQ_COUNT, 32'sd5);
		issue_request(REQ_SPARE_LO, -32'sd1);
		issue_request(REQ_SPARE_HI, 32'sh7fff_ffff);
		foreach (fill_values[k]) begin
			issue_request(k[0] ? ale_pkg::REQ_INS_BACK : ale_pkg::REQ_INS_FRONT, fill_values[k]);
			maybe_gap(1'b0);
		end
		issue_request(ale_pkg::REQ_INS_FRONT, 32'sd9);
		issue_request(ale_pkg::REQ_INS_BACK, 32'sd9);
		issue_request(ale_pkg::REQ_COUNT, 32'sd5);
		issue_request(ale_pkg::REQ_COUNT, 32'sh7fff_ffff);
		issue_request(ale_pkg::REQ_REMOVE, 32'sd5);
		issue_request(ale_pkg::REQ_POP_FRONT, 32'sd0);
		issue_request(ale_pkg::REQ_POP_BACK, 32'sd0);
		issue_request(ale_pkg::REQ_REMOVE, 32'sd77);
		drain();

		filling = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 30 == 0)
				filling = !filling || i == 0;
			if (i == 300)
				drain();
			issue_request(pick_request(filling), pick_value());
			maybe_gap(i >= 150 && i < 250);
		end
		drain();

		$display("Ran %0d requests, %0d results: %0d full, %0d empty refusals, %0d misses",
			tracker.requests, tracker.results, tracker.full_refusals, tracker.empty_refusals,
			tracker.misses);
		$display("Mismatches: %0d, results still outstanding: %0d", tracker.mismatches,
			tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ale_pkg.sv
hw/rtl/ale_cell.sv
hw/rtl/array_list_engine_top.sv
tb/testbench.sv
